// ===== sv/mur_pkg.sv =====
// shared constants and types for the mini uart register block
package mur_pkg;

  localparam int RX_DEPTH_DEF = 8;
  localparam int TX_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2,
    CMD_DRAIN = 2'd3
  } cmd_t;

  // register offsets in the 256-byte window
  localparam logic [7:0] OFF_IRQ  = 8'h00;
  localparam logic [7:0] OFF_ID   = 8'h04;
  localparam logic [7:0] OFF_DATA = 8'h40;
  localparam logic [7:0] OFF_IER  = 8'h44;
  localparam logic [7:0] OFF_IIR  = 8'h48;
  localparam logic [7:0] OFF_LSR  = 8'h54;
  localparam logic [7:0] OFF_CNTL = 8'h60;
  localparam logic [7:0] OFF_STAT = 8'h64;

  localparam logic [31:0] ID_VALUE      = 32'h0000_0001;
  localparam logic [31:0] RX_EMPTY_DATA = 32'h0000_00FF;
  localparam logic [31:0] IER_BASE      = 32'h0000_00C0;
  localparam logic [31:0] IIR_BASE      = 32'h0000_00C0;
  localparam logic [31:0] IIR_RX        = 32'h0000_0004;
  localparam logic [31:0] IIR_TX        = 32'h0000_0002;
  localparam logic [31:0] IIR_NONE      = 32'h0000_0001;
  localparam logic [31:0] LSR_BASE      = 32'h0000_0060;
  localparam logic [31:0] STAT_BASE     = 32'h0000_030E;
  localparam int          STAT_LVL_LSB  = 16;

  localparam logic [7:0] IRQ_PEND_RST = 8'hC1;
  localparam logic [1:0] UART_EN_RST  = 2'b11;

endpackage

// ===== sv/mini_uart_register_block.sv =====
// mini uart register block: bus decode, rx/tx fifos and interrupt state
// One request is taken per clock and its result lands in the output register on the same edge,
// so the block sustains one request per cycle; the only limit is the output register, which
// holds a result while out_stall is high and stalls the input side until it is taken. Every
// request (bus read, bus write, line byte, drain tick) is decoded and applied to the fifo
// pointers and interrupt bits when accepted. Fifo storage has no reset; a data read of an empty
// rx fifo returns 0xFF. A data write with tx enabled and room sends the oldest byte at once.
module mini_uart_register_block_top
  import mur_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  offset,
  input  logic [31:0] write_data,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        irq,
  output logic        tx_overflow
);

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int RCW = $clog2(RX_DEPTH + 1);
  localparam int TPW = $clog2(TX_DEPTH);
  localparam int TCW = $clog2(TX_DEPTH + 1);

  localparam logic [RCW-1:0] RX_FULL = RCW'(RX_DEPTH);
  localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);
  localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
  localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);
  localparam logic [RCW:0]   RX_DEPTH_W = (RCW + 1)'(RX_DEPTH);
  localparam logic [TCW:0]   TX_DEPTH_W = (TCW + 1)'(TX_DEPTH);

  logic [7:0]     rx_store [RX_DEPTH];
  logic [7:0]     tx_store [TX_DEPTH];
  logic [RPW-1:0] rx_head, rx_head_next;
  logic [RCW-1:0] rx_count, rx_count_next;
  logic [TPW-1:0] tx_head, tx_head_next;
  logic [TCW-1:0] tx_count, tx_count_next;
  logic [1:0]     irq_en, irq_en_next;
  logic [1:0]     uart_en, uart_en_next;
  logic [7:0]     irq_pending, irq_pending_next;

  logic           accept;
  logic           has_rx;
  logic           refresh;
  logic           rx_we, tx_we;
  logic [RCW:0]   rx_wr_sum;
  logic [TCW:0]   tx_wr_sum;
  logic [RPW-1:0] rx_wr_idx, rx_head_inc;
  logic [TPW-1:0] tx_wr_idx, tx_head_inc;
  logic [31:0]    rd_val;
  logic           txv;
  logic [7:0]     txb;
  logic           ovf;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign has_rx   = rx_count != '0;

  // write slot is head + count modulo depth, the sum stays below twice the depth
  always_comb begin
    rx_wr_sum = (RCW + 1)'(rx_head) + (RCW + 1)'(rx_count);
    if (rx_wr_sum >= RX_DEPTH_W) begin
      rx_wr_sum = rx_wr_sum - RX_DEPTH_W;
    end
    rx_wr_idx = rx_wr_sum[RPW-1:0];
    tx_wr_sum = (TCW + 1)'(tx_head) + (TCW + 1)'(tx_count);
    if (tx_wr_sum >= TX_DEPTH_W) begin
      tx_wr_sum = tx_wr_sum - TX_DEPTH_W;
    end
    tx_wr_idx = tx_wr_sum[TPW-1:0];
    rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
    tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
  end

  always_comb begin
    rx_head_next  = rx_head;
    rx_count_next = rx_count;
    tx_head_next  = tx_head;
    tx_count_next = tx_count;
    irq_en_next   = irq_en;
    uart_en_next  = uart_en;
    refresh       = 1'b0;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    rd_val        = '0;
    txv           = 1'b0;
    txb           = '0;
    ovf           = 1'b0;
    case (cmd_t'(command))
      CMD_READ: begin
        case (offset)
          OFF_IRQ:  rd_val = {31'b0, irq_pending != '0};
          OFF_ID:   rd_val = ID_VALUE;
          OFF_DATA: begin
            refresh = 1'b1;
            if (has_rx) begin
              rd_val        = {24'b0, rx_store[rx_head]};
              rx_head_next  = rx_head_inc;
              rx_count_next = rx_count - 1'b1;
            end else begin
              rd_val = RX_EMPTY_DATA;
            end
          end
          OFF_IER:  rd_val = IER_BASE | {30'b0, irq_en};
          OFF_IIR:  rd_val = IIR_BASE | (has_rx ? IIR_RX : IIR_TX) |
                             ((irq_pending == '0) ? IIR_NONE : '0);
          OFF_LSR:  rd_val = LSR_BASE | {31'b0, has_rx};
          OFF_CNTL: rd_val = {30'b0, uart_en};
          OFF_STAT: rd_val = STAT_BASE | (has_rx ?
                             ((32'(rx_count) << STAT_LVL_LSB) | 32'd1) : '0);
          default:  rd_val = '0;
        endcase
      end
      CMD_WRITE: begin
        refresh = 1'b1;
        case (offset)
          OFF_DATA: begin
            if (tx_count == TX_FULL) begin
              ovf = 1'b1;
            end else begin
              tx_we = 1'b1;
              if (uart_en[1]) begin
                // push then pop: the oldest byte goes out, count is unchanged
                txv          = 1'b1;
                txb          = (tx_count == '0) ? write_data[7:0] : tx_store[tx_head];
                tx_head_next = tx_head_inc;
              end else begin
                tx_count_next = tx_count + 1'b1;
              end
            end
          end
          OFF_IER:  irq_en_next = write_data[1:0];
          OFF_IIR: begin
            if (write_data[1]) begin
              rx_head_next  = '0;
              rx_count_next = '0;
            end
          end
          OFF_CNTL: uart_en_next = write_data[1:0];
          default: ;
        endcase
      end
      CMD_RX: begin
        if (uart_en[0] && rx_count != RX_FULL) begin
          rx_we         = 1'b1;
          rx_count_next = rx_count + 1'b1;
          refresh       = 1'b1;
        end
      end
      CMD_DRAIN: begin
        if (tx_count == '0) begin
          refresh = 1'b1;
        end else if (uart_en[1]) begin
          txv           = 1'b1;
          txb           = tx_store[tx_head];
          tx_head_next  = tx_head_inc;
          tx_count_next = tx_count - 1'b1;
        end
      end
      default: ;
    endcase
    irq_pending_next = refresh ?
        {6'b0, irq_en_next[1] && tx_count_next == '0, irq_en_next[0] && rx_count_next != '0} :
        irq_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head     <= '0;
      rx_count    <= '0;
      tx_head     <= '0;
      tx_count    <= '0;
      irq_en      <= '0;
      uart_en     <= UART_EN_RST;
      irq_pending <= IRQ_PEND_RST;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        rx_head     <= rx_head_next;
        rx_count    <= rx_count_next;
        tx_head     <= tx_head_next;
        tx_count    <= tx_count_next;
        irq_en      <= irq_en_next;
        uart_en     <= uart_en_next;
        irq_pending <= irq_pending_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rx_we) begin
      rx_store[rx_wr_idx] <= rx_byte;
    end
    if (accept && tx_we) begin
      tx_store[tx_wr_idx] <= write_data[7:0];
    end
    if (accept) begin
      read_data   <= rd_val;
      tx_valid    <= txv;
      tx_byte     <= txb;
      irq         <= irq_pending_next != '0;
      tx_overflow <= ovf;
    end
  end

  // a dropped write never sends a byte in the same result
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tx_valid && tx_overflow))
    else $error("tx_valid and tx_overflow both set");

  assert property (@(posedge clk) disable iff (rst)
    rx_count <= RX_FULL && tx_count <= TX_FULL)
    else $error("fifo count beyond depth");

  // an arriving byte with room and rx enabled is always queued
  assert property (@(posedge clk) disable iff (rst)
    accept && cmd_t'(command) == CMD_RX && uart_en[0] && rx_count != RX_FULL
    |=> rx_count == $past(rx_count) + 1'b1)
    else $error("rx byte not queued");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == '0)
    else $error("tx_byte nonzero without tx_valid");

endmodule
